### sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared payload types and constants for the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int unsigned CORNERS = 3;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               degenerate;
  } normal_t;

  // Word handed from the front to the back: the three corners of one triangle.
  typedef struct packed {
    logic signed [47:0] p0_x;
    logic signed [47:0] p0_y;
    logic signed [47:0] p0_z;
    logic signed [47:0] p1_x;
    logic signed [47:0] p1_y;
    logic signed [47:0] p1_z;
    logic signed [47:0] p2_x;
    logic signed [47:0] p2_y;
    logic signed [47:0] p2_z;
  } tri_t;

endpackage

### sv/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal of a stream of triangles, Q16.16 in, Q2.30 out.
// ----------------------------------------------------------------------------
//  channel | direction | word                 | handshake
//  in      | input     | vertex_t (x, y, z)   | in_valid / in_ready
//  out     | output    | normal_t (n, degen)  | out_valid / out_ready
//
// The first two corners of a triangle are taken whenever valid; the third
// one passes into a two-entry queue and waits while the queue is full. The
// back end steps through accept, edges, six products, cross and scaling,
// the sum of squares, the bit-serial root, three divisions and an output
// state; a degenerate triangle goes from scaling straight to the output.
// Reset clears the corner phase, queue and back-end state.
// A stalled output holds the back end; the queue takes up to two more
// triangles, then the third corner of the next one waits.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tun_pkg::vertex_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tun_pkg::normal_t out_data
);

  logic          f_valid, f_ready;
  tun_pkg::tri_t f_word;
  logic          q_valid, q_ready;
  tun_pkg::tri_t q_word;

  // Gather corners.
  tun_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_word(in_data),
    .tri_valid(f_valid), .tri_ready(f_ready), .tri_word(f_word)
  );

  // Decouple front and back.
  tun_fifo u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_word(f_word),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
  );

  // Compute and hold the normal until taken.
  tun_back u_back (
    .clk, .rst, .tri_valid(q_valid), .tri_ready(q_ready), .tri_word(q_word),
    .out_valid, .out_ready, .out_word(out_data)
  );

endmodule

### sv/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Collect vertices into triangles; hand each full triangle to the queue.
// ----------------------------------------------------------------------------
module tun_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tun_pkg::vertex_t in_word,
  output logic            tri_valid,
  input  logic            tri_ready,
  output tun_pkg::tri_t   tri_word
);

  // Widths above 32 cannot arrive on a 32-bit port; clamp the select range.
  localparam int SEL_WIDTH = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  logic [1:0] corner_phase;
  logic signed [47:0] first_corner  [tun_pkg::CORNERS];
  logic signed [47:0] second_corner [tun_pkg::CORNERS];
  logic signed [47:0] p [tun_pkg::CORNERS];

  function automatic logic signed [47:0] sext(input logic [31:0] raw);
    logic signed [47:0] v;
    begin
      v = 48'(signed'(raw[SEL_WIDTH-1:0]));
      return v;
    end
  endfunction

  always_comb begin
    p[0] = sext(in_word.vertex_x);
    p[1] = sext(in_word.vertex_y);
    p[2] = sext(in_word.vertex_z);
  end

  assign in_ready  = (corner_phase != 2'd2) || tri_ready;
  assign tri_valid = in_valid && (corner_phase == 2'd2);
  assign tri_word  = '{first_corner[0], first_corner[1], first_corner[2],
                       second_corner[0], second_corner[1], second_corner[2],
                       p[0], p[1], p[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_phase <= 2'd0;
    end else if (in_valid && in_ready) begin
      priority case (corner_phase)
        2'd1:    corner_phase <= 2'd2;
        2'd2:    corner_phase <= 2'd0;
        default: corner_phase <= 2'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tun_pkg::CORNERS; i++) begin
        first_corner[i]  <= '0;
        second_corner[i] <= '0;
      end
    end else if (in_valid && in_ready) begin
      if (corner_phase == 2'd1) begin
        second_corner <= p;
      end else if (corner_phase != 2'd2) begin
        first_corner <= p;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) corner_phase != 2'd3)
    else $error("corner phase out of range");
  assert property (@(posedge clk) disable iff (rst)
    tri_valid |-> (corner_phase == 2'd2))
    else $error("triangle issued before third corner");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && corner_phase == 2'd2) |=> (corner_phase == 2'd0))
    else $error("phase did not wrap");

endmodule

### sv/tun_fifo.sv
// ----------------------------------------------------------------------------
// tun_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module tun_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tun_pkg::tri_t wr_word,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tun_pkg::tri_t rd_word
);

  tun_pkg::tri_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_word  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_word;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && do_wr) |=> (count == 2'd1))
    else $error("queue fill miscounted");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !do_rd) |=> (count == 2'd2))
    else $error("full queue lost an entry");

endmodule

### sv/tun_back.sv
// ----------------------------------------------------------------------------
// tun_back
// Cross product, normalize, root and three divisions for one triangle.
// ----------------------------------------------------------------------------
module tun_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            tri_valid,
  output logic            tri_ready,
  input  tun_pkg::tri_t   tri_word,
  output logic            out_valid,
  input  logic            out_ready,
  output tun_pkg::normal_t out_word
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EDGE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_CROSS = 9'b000001000,
    S_NORM  = 9'b000010000,
    S_SQR   = 9'b000100000,
    S_ROOT  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic signed [48:0] a [3];
  logic signed [48:0] b [3];
  logic signed [97:0] prod [6];
  logic [98:0]  cmag [3];
  logic         cneg [3];
  logic [30:0]  m [3];
  logic [2:0]   mul_idx;
  logic [63:0]  s;
  logic [63:0]  rem;
  logic [31:0]  root;
  logic [5:0]   step;
  logic [1:0]   lane;
  logic [61:0]  num;
  logic [32:0]  quo;
  logic [32:0]  drem;
  logic [31:0]  nres [3];
  logic         degen;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  // Bit length of one magnitude, found by priority logic.
  function automatic logic [6:0] blen(input logic [98:0] v);
    logic [6:0] r;
    begin
      r = '0;
      for (int i = 0; i < 99; i++) if (v[i]) r = 7'(i + 1);
      return r;
    end
  endfunction

  // Edges of 32-bit corners fit in 33 bits.
  always_comb begin
    unique case (mul_idx)
      3'd0:    begin mul_a = 33'(a[1]); mul_b = 33'(b[2]); end
      3'd1:    begin mul_a = 33'(a[2]); mul_b = 33'(b[1]); end
      3'd2:    begin mul_a = 33'(a[2]); mul_b = 33'(b[0]); end
      3'd3:    begin mul_a = 33'(a[0]); mul_b = 33'(b[2]); end
      3'd4:    begin mul_a = 33'(a[0]); mul_b = 33'(b[1]); end
      default: begin mul_a = 33'(a[1]); mul_b = 33'(b[0]); end
    endcase
    mul_p = mul_a * mul_b;
  end

  logic [6:0]  l0, l1, l2, lmax;
  logic [61:0] msq;

  always_comb begin
    l0 = blen(cmag[0]);
    l1 = blen(cmag[1]);
    l2 = blen(cmag[2]);
    lmax = l0;
    if (l1 > lmax) lmax = l1;
    if (l2 > lmax) lmax = l2;
    msq = m[lane] * m[lane];
  end

  assign tri_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (tri_valid) state <= S_EDGE;
        S_EDGE: state <= S_MUL;
        S_MUL:  if (mul_idx == 3'd5) state <= S_CROSS;
        S_CROSS: state <= S_NORM;
        S_NORM: state <= (lmax == 7'd0) ? S_OUT : S_SQR;
        S_SQR:  if (lane == 2'd2) state <= S_ROOT;
        S_ROOT: if (step == 6'd31) state <= S_DIV;
        S_DIV:  if (lane == 2'd2 && step == 6'd61) state <= S_OUT;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        a[0] <= 49'(tri_word.p1_x) - 49'(tri_word.p0_x);
        a[1] <= 49'(tri_word.p1_y) - 49'(tri_word.p0_y);
        a[2] <= 49'(tri_word.p1_z) - 49'(tri_word.p0_z);
        b[0] <= 49'(tri_word.p2_x) - 49'(tri_word.p0_x);
        b[1] <= 49'(tri_word.p2_y) - 49'(tri_word.p0_y);
        b[2] <= 49'(tri_word.p2_z) - 49'(tri_word.p0_z);
        mul_idx <= 3'd0;
      end
      S_EDGE: mul_idx <= 3'd0;
      S_MUL: begin
        prod[mul_idx] <= 98'(mul_p);
        mul_idx <= mul_idx + 3'd1;
      end
      S_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [98:0] c;
          c = 99'(prod[2*i]) - 99'(prod[2*i+1]);
          cneg[i] <= c[98];
          cmag[i] <= c[98] ? 99'(-c) : 99'(c);
        end
      end
      S_NORM: begin
        degen <= (lmax == 7'd0);
        for (int i = 0; i < 3; i++) begin
          if (lmax > 7'd31) m[i] <= 31'(cmag[i] >> (lmax - 7'd31));
          else m[i] <= 31'(cmag[i] << (7'd31 - lmax));
        end
        s <= '0;
        lane <= 2'd0;
      end
      S_SQR: begin
        s <= s + 64'(msq);
        lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        if (lane == 2'd2) begin
          rem <= '0;
          root <= '0;
          step <= '0;
        end
      end
      S_ROOT: begin
        // One result bit per cycle, two radicand bits shifted in.
        logic [65:0] r2;
        logic [65:0] t2;
        logic [31:0] rt;
        r2 = {rem, s[63:62]};
        t2 = {32'd0, root, 2'b01};
        if (r2 >= t2) begin
          rem <= 64'(r2 - t2);
          rt  = {root[30:0], 1'b1};
        end else begin
          rem <= 64'(r2);
          rt  = {root[30:0], 1'b0};
        end
        root <= rt;
        s    <= {s[61:0], 2'b00};
        if (step == 6'd31) begin
          step <= '0;
          lane <= 2'd0;
          num  <= 62'({m[0], 30'd0}) + 62'(rt[31:1]);
          drem <= '0;
          quo  <= '0;
        end else begin
          step <= step + 6'd1;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        logic [32:0] r1;
        logic        qbit;
        logic [32:0] q_next;
        r1 = {drem[31:0], num[61]};
        qbit = (r1 >= {1'b0, root});
        q_next = {quo[31:0], qbit};
        if (step == 6'd61) begin
          nres[lane] <= cneg[lane] ? 32'(-q_next) : q_next[31:0];
          step <= '0;
          lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
          drem <= '0;
          quo  <= '0;
          if (lane != 2'd2) num <= 62'({m[lane + 2'd1], 30'd0}) + 62'(root[31:1]);
        end else begin
          drem <= qbit ? r1 - {1'b0, root} : r1;
          quo  <= q_next;
          num  <= {num[60:0], 1'b0};
          step <= step + 6'd1;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  assign out_word.normal_x   = degen ? '0 : nres[0];
  assign out_word.normal_y   = degen ? '0 : nres[1];
  assign out_word.normal_z   = degen ? '0 : nres[2];
  assign out_word.degenerate = degen;

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> !degen)
    else $error("root on degenerate triangle");

endmodule

### sim/triangle_unit_normal_top_tb.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top_tb
// Drives vertex streams into the unit normal block and checks every normal
// against a cycle-free predictor of the exact cross product and its scaling.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected normals and the corner state that produces them.
  class normal_scoreboard;
    tun_pkg::normal_t    pending_normals[$];
    logic signed [31:0]  corner0[3];
    logic signed [31:0]  corner1[3];
    int unsigned         phase;
    int unsigned         errors;

    function new();
      phase = 0;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        corner0[i] = '0;
        corner1[i] = '0;
      end
    endfunction

    function logic [63:0] root64(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Take one vertex; queue a normal on the third corner.
    function void note_vertex(tun_pkg::vertex_t v);
      logic signed [31:0]  p[3];
      logic signed [63:0]  a[3];
      logic signed [63:0]  b[3];
      logic signed [127:0] c[3];
      logic [127:0]        mag[3];
      logic [63:0]         m[3];
      logic [63:0]         s;
      logic [63:0]         root;
      logic [63:0]         q;
      int                  len;
      tun_pkg::normal_t    n;
      p[0] = v.vertex_x;
      p[1] = v.vertex_y;
      p[2] = v.vertex_z;
      if (phase == 1) begin
        for (int i = 0; i < 3; i++) corner1[i] = p[i];
        phase = 2;
        return;
      end
      if (phase != 2) begin
        for (int i = 0; i < 3; i++) corner0[i] = p[i];
        phase = 1;
        return;
      end
      phase = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = 64'(corner1[i]) - 64'(corner0[i]);
        b[i] = 64'(p[i]) - 64'(corner0[i]);
      end
      c[0] = 128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1]);
      c[1] = 128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2]);
      c[2] = 128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0]);
      len = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i] < 0 ? -c[i] : c[i];
        for (int k = 0; k < 128; k++) if (mag[i][k] && k + 1 > len) len = k + 1;
      end
      n = '0;
      if (len == 0) begin
        n.degenerate = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (len > 31) m[i] = 64'(mag[i] >> (len - 31));
          else m[i] = 64'(mag[i]) << (31 - len);
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = root64(s);
        for (int i = 0; i < 3; i++) begin
          q = ((m[i] << 30) + (root >> 1)) / root;
          if (c[i] < 0) q = -q;
          if (i == 0) n.normal_x = q[31:0];
          else if (i == 1) n.normal_y = q[31:0];
          else n.normal_z = q[31:0];
        end
      end
      pending_normals = {pending_normals, n};
    endfunction

    function void check_normal(tun_pkg::normal_t got);
      tun_pkg::normal_t want;
      if (pending_normals.size() == 0) begin
        $error("unexpected normal %h", got);
        errors++;
        return;
      end
      want = pending_normals.pop_front();
      if (got.normal_x !== want.normal_x) begin
        $error("normal_x expected %h got %h", want.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== want.normal_y) begin
        $error("normal_y expected %h got %h", want.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== want.normal_z) begin
        $error("normal_z expected %h got %h", want.normal_z, got.normal_z);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate expected %b got %b", want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_PCT   = 29;
  localparam int STALL_LIMIT = 20000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  tun_pkg::vertex_t in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  tun_pkg::normal_t out_data;

  normal_scoreboard normals = new();
  bit      idle_enable = 1'b1;
  int      quiet_cycles = 0;

  triangle_unit_normal_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample both channels at the rising edge; predict on every accepted word.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) normals.note_vertex(in_data);
      if (out_valid && out_ready) normals.check_normal(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: stop when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stall at random, except during the no-idle stretch.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !idle_enable || ($urandom_range(99) >= IDLE_PCT);
  end

  // Present one vertex and hold it until accepted; idle cycles drop valid.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (idle_enable) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{vertex_x: x, vertex_y: y, vertex_z: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_triangle(logic [31:0] v[9]);
    for (int i = 0; i < 3; i++) send_vertex(v[3*i], v[3*i+1], v[3*i+2]);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                       : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  initial begin
    logic [31:0] t[9];
    int          mode;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unit axes, reversed winding, extremes, degenerate cases.
    t = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
    send_triangle(t);
    t = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};
    send_triangle(t);
    t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_triangle(t);
    t = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    send_triangle(t);
    t = '{5, 5, 5, 5, 5, 5, 5, 5, 5};         // all corners coincide
    send_triangle(t);
    t = '{0, 0, 0, 1, 1, 1, 2, 2, 2};         // collinear corners
    send_triangle(t);
    t = '{0, 0, 0, 1, 0, 0, 0, 1, 0};         // smallest nonzero area
    send_triangle(t);
    t = '{32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF};
    send_triangle(t);

    // Random triangles; one long stretch with no idling on either side.
    for (int n = 0; n < 530; n++) begin
      idle_enable = !(n >= 200 && n < 280);
      mode = $urandom_range(3);
      for (int i = 0; i < 9; i++) t[i] = rand_coord(mode);
      if ($urandom_range(19) == 0) for (int i = 6; i < 9; i++) t[i] = t[i-3];
      send_triangle(t);
    end
    in_valid <= 1'b0;
    idle_enable = 1'b1;

    while (normals.pending_normals.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (normals.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
